FILE: rtl/nmea_rmc_field_extractor_assert.svh
// Assertion macros shared by the sentence extractor RTL.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NMEA_RMC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NMEA_RMC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nmea_rmc_pkg.sv
// Types and constants for the RMC sentence field extractor.
`default_nettype none

package nmea_rmc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] comma_cnt_t;

  // Characters of interest
  localparam char_t CHAR_DOLLAR = 8'h24;
  localparam char_t CHAR_COMMA  = 8'h2C;
  localparam char_t CHAR_LF     = 8'h0A;
  localparam char_t CHAR_A      = 8'h41;

  // Sentence header "$GPRMC,"
  localparam int HDR_LEN = 7;
  localparam char_t HDR_TEXT [HDR_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C};

  // Field numbers (field k starts after comma k)
  localparam int FIELD_TIME     = 1;
  localparam int FIELD_STATUS   = 2;
  localparam int FIELD_LAT      = 3;
  localparam int FIELD_LAT_HEMI = 4;
  localparam int FIELD_LON      = 5;
  localparam int FIELD_LON_HEMI = 6;
  localparam int FIELD_DATE     = 9;
  localparam int MIN_COMMAS     = 9;
  localparam int COMMA_MAX      = 15;

  // Window lengths in characters
  localparam int TIME_LEN    = 6;
  localparam int DATE_LEN    = 6;
  localparam int LAT_LEN     = 8;
  localparam int LON_DEG_LEN = 3;
  localparam int LON_MIN_LEN = 6;
  localparam int LON_LEN     = LON_DEG_LEN + LON_MIN_LEN;

  // One result item
  typedef struct packed {
    logic        fix_valid;
    logic [47:0] utc_time_chars;
    logic [47:0] date_chars;
    logic [63:0] latitude_chars;
    logic [7:0]  lat_hemisphere;
    logic [23:0] lon_degree_chars;
    logic [47:0] lon_minute_chars;
    logic [7:0]  lon_hemisphere;
  } fix_t;

  // Header matcher status
  typedef struct packed {
    logic       done;
    logic [2:0] pos;
  } hdr_stat_t;

  // Sentence tracker status
  typedef struct packed {
    logic       in_sentence;
    comma_cnt_t comma_count;
  } sent_stat_t;

endpackage

`default_nettype wire

FILE: rtl/nmea_rmc_if.sv
// Valid/ready channel interfaces for received bytes and extracted fixes.
`default_nettype none

interface nmea_rmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nmea_rmc_out_if;
  logic        valid;
  logic        ready;
  logic        fix_valid;
  logic [47:0] utc_time_chars;
  logic [47:0] date_chars;
  logic [63:0] latitude_chars;
  logic [7:0]  lat_hemisphere;
  logic [23:0] lon_degree_chars;
  logic [47:0] lon_minute_chars;
  logic [7:0]  lon_hemisphere;

  modport source (
    output valid, output fix_valid, output utc_time_chars, output date_chars,
    output latitude_chars, output lat_hemisphere, output lon_degree_chars,
    output lon_minute_chars, output lon_hemisphere, input ready
  );
  modport sink (
    input valid, input fix_valid, input utc_time_chars, input date_chars,
    input latitude_chars, input lat_hemisphere, input lon_degree_chars,
    input lon_minute_chars, input lon_hemisphere, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/nmea_rmc_hdr.sv
// Header matcher: finds "$GPRMC," in the byte stream between sentences.
`default_nettype none

module nmea_rmc_hdr (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_take,
  input  wire nmea_rmc_pkg::char_t   rx_byte,
  input  wire logic                  in_sentence,
  output nmea_rmc_pkg::hdr_stat_t    stat
);

  logic [2:0] pos;
  logic [2:0] pos_next;
  logic       match;
  logic       done;

  // Compare against the expected header character
  always_comb begin
    match = (rx_byte == nmea_rmc_pkg::HDR_TEXT[pos]);
    done  = byte_take && !in_sentence && match &&
            (pos == 3'(nmea_rmc_pkg::HDR_LEN - 1));
  end

  // Advance on match, restart on mismatch; a '$' restarts at one
  always_comb begin
    pos_next = pos;
    if (byte_take && !in_sentence) begin
      if (done) begin
        pos_next = '0;
      end else if (match) begin
        pos_next = pos + 3'd1;
      end else if (rx_byte == nmea_rmc_pkg::CHAR_DOLLAR) begin
        pos_next = 3'd1;
      end else begin
        pos_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  assign stat.done = done;
  assign stat.pos  = pos;

endmodule

`default_nettype wire

FILE: rtl/nmea_rmc_fields.sv
// Sentence tracker: counts commas, captures field windows, forms the result.
`default_nettype none

module nmea_rmc_fields (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_take,
  input  wire nmea_rmc_pkg::char_t   rx_byte,
  input  wire logic                  hdr_done,
  output logic                       res_valid,
  output nmea_rmc_pkg::fix_t         res,
  output nmea_rmc_pkg::sent_stat_t   stat
);

  // Control state
  logic                     in_sentence, in_sentence_next;
  nmea_rmc_pkg::comma_cnt_t comma_count, comma_count_next;
  logic                     status_pending, status_pending_next;
  logic [2:0]               rem_time, rem_time_next;
  logic [2:0]               rem_date, rem_date_next;
  logic [3:0]               rem_lat, rem_lat_next;
  logic                     rem_lath, rem_lath_next;
  logic [3:0]               rem_lon, rem_lon_next;
  logic                     rem_lonh, rem_lonh_next;

  // Payload state
  nmea_rmc_pkg::char_t status_char, status_char_next;
  nmea_rmc_pkg::char_t time_w    [nmea_rmc_pkg::TIME_LEN];
  nmea_rmc_pkg::char_t date_w    [nmea_rmc_pkg::DATE_LEN];
  nmea_rmc_pkg::char_t lat_w     [nmea_rmc_pkg::LAT_LEN];
  nmea_rmc_pkg::char_t lath_w;
  nmea_rmc_pkg::char_t lon_deg_w [nmea_rmc_pkg::LON_DEG_LEN];
  nmea_rmc_pkg::char_t lon_min_w [nmea_rmc_pkg::LON_MIN_LEN];
  nmea_rmc_pkg::char_t lonh_w;

  // Windows after this byte is captured
  nmea_rmc_pkg::char_t status_cap;
  nmea_rmc_pkg::char_t time_cap    [nmea_rmc_pkg::TIME_LEN];
  nmea_rmc_pkg::char_t date_cap    [nmea_rmc_pkg::DATE_LEN];
  nmea_rmc_pkg::char_t lat_cap     [nmea_rmc_pkg::LAT_LEN];
  nmea_rmc_pkg::char_t lath_cap;
  nmea_rmc_pkg::char_t lon_deg_cap [nmea_rmc_pkg::LON_DEG_LEN];
  nmea_rmc_pkg::char_t lon_min_cap [nmea_rmc_pkg::LON_MIN_LEN];
  nmea_rmc_pkg::char_t lonh_cap;

  // Next window values
  nmea_rmc_pkg::char_t time_w_next    [nmea_rmc_pkg::TIME_LEN];
  nmea_rmc_pkg::char_t date_w_next    [nmea_rmc_pkg::DATE_LEN];
  nmea_rmc_pkg::char_t lat_w_next     [nmea_rmc_pkg::LAT_LEN];
  nmea_rmc_pkg::char_t lath_w_next;
  nmea_rmc_pkg::char_t lon_deg_w_next [nmea_rmc_pkg::LON_DEG_LEN];
  nmea_rmc_pkg::char_t lon_min_w_next [nmea_rmc_pkg::LON_MIN_LEN];
  nmea_rmc_pkg::char_t lonh_w_next;

  logic                     take;
  logic                     is_comma;
  logic                     is_lf;
  logic                     fix_ok;
  nmea_rmc_pkg::comma_cnt_t comma_inc;
  logic [2:0]               time_idx, date_idx, lat_idx, lon_min_idx;
  logic [1:0]               lon_deg_idx;

  assign take      = byte_take && in_sentence;
  assign is_comma  = (rx_byte == nmea_rmc_pkg::CHAR_COMMA);
  assign is_lf     = (rx_byte == nmea_rmc_pkg::CHAR_LF);
  assign comma_inc = comma_count + 4'd1;

  // Window write positions, counted from the first character
  assign time_idx    = 3'(nmea_rmc_pkg::TIME_LEN) - rem_time;
  assign date_idx    = 3'(nmea_rmc_pkg::DATE_LEN) - rem_date;
  assign lat_idx     = 3'(4'(nmea_rmc_pkg::LAT_LEN) - rem_lat);
  assign lon_deg_idx = 2'(4'(nmea_rmc_pkg::LON_LEN) - rem_lon);
  assign lon_min_idx = 3'(4'(nmea_rmc_pkg::LON_MIN_LEN) - rem_lon);

  // Capture the byte into every active window and the status slot
  always_comb begin
    status_cap  = status_char;
    time_cap    = time_w;
    date_cap    = date_w;
    lat_cap     = lat_w;
    lath_cap    = lath_w;
    lon_deg_cap = lon_deg_w;
    lon_min_cap = lon_min_w;
    lonh_cap    = lonh_w;
    if (take) begin
      if (status_pending) begin
        status_cap = rx_byte;
      end
      if (rem_time != '0) begin
        time_cap[time_idx] = rx_byte;
      end
      if (rem_date != '0) begin
        date_cap[date_idx] = rx_byte;
      end
      if (rem_lat != '0) begin
        lat_cap[lat_idx] = rx_byte;
      end
      if (rem_lath) begin
        lath_cap = rx_byte;
      end
      if (rem_lon > 4'(nmea_rmc_pkg::LON_MIN_LEN)) begin
        lon_deg_cap[lon_deg_idx] = rx_byte;
      end else if (rem_lon != '0) begin
        lon_min_cap[lon_min_idx] = rx_byte;
      end
      if (rem_lonh) begin
        lonh_cap = rx_byte;
      end
    end
  end

  // Pack the result; a sentence without a valid fix reads as all zero
  always_comb begin
    fix_ok    = (status_cap == nmea_rmc_pkg::CHAR_A) &&
                (comma_count >= 4'(nmea_rmc_pkg::MIN_COMMAS));
    res_valid = take && is_lf;
    res       = '0;
    if (fix_ok) begin
      res.fix_valid = 1'b1;
      for (int k = 0; k < nmea_rmc_pkg::TIME_LEN; k++) begin
        res.utc_time_chars[8*(nmea_rmc_pkg::TIME_LEN-1-k) +: 8] = time_cap[k];
      end
      for (int k = 0; k < nmea_rmc_pkg::DATE_LEN; k++) begin
        res.date_chars[8*(nmea_rmc_pkg::DATE_LEN-1-k) +: 8] = date_cap[k];
      end
      for (int k = 0; k < nmea_rmc_pkg::LAT_LEN; k++) begin
        res.latitude_chars[8*(nmea_rmc_pkg::LAT_LEN-1-k) +: 8] = lat_cap[k];
      end
      for (int k = 0; k < nmea_rmc_pkg::LON_DEG_LEN; k++) begin
        res.lon_degree_chars[8*(nmea_rmc_pkg::LON_DEG_LEN-1-k) +: 8] = lon_deg_cap[k];
      end
      for (int k = 0; k < nmea_rmc_pkg::LON_MIN_LEN; k++) begin
        res.lon_minute_chars[8*(nmea_rmc_pkg::LON_MIN_LEN-1-k) +: 8] = lon_min_cap[k];
      end
      res.lat_hemisphere = lath_cap;
      res.lon_hemisphere = lonh_cap;
    end
  end

  // Control next state: open on header, count commas, close on newline
  always_comb begin
    in_sentence_next    = in_sentence;
    comma_count_next    = comma_count;
    status_pending_next = status_pending;
    rem_time_next       = rem_time;
    rem_date_next       = rem_date;
    rem_lat_next        = rem_lat;
    rem_lath_next       = rem_lath;
    rem_lon_next        = rem_lon;
    rem_lonh_next       = rem_lonh;
    if (hdr_done) begin
      in_sentence_next    = 1'b1;
      comma_count_next    = 4'(nmea_rmc_pkg::FIELD_TIME);
      status_pending_next = 1'b0;
      rem_time_next       = 3'(nmea_rmc_pkg::TIME_LEN);
      rem_date_next       = '0;
      rem_lat_next        = '0;
      rem_lath_next       = 1'b0;
      rem_lon_next        = '0;
      rem_lonh_next       = 1'b0;
    end else if (take) begin
      status_pending_next = 1'b0;
      if (rem_time != '0) rem_time_next = rem_time - 3'd1;
      if (rem_date != '0) rem_date_next = rem_date - 3'd1;
      if (rem_lat != '0) rem_lat_next = rem_lat - 4'd1;
      if (rem_lon != '0) rem_lon_next = rem_lon - 4'd1;
      rem_lath_next = 1'b0;
      rem_lonh_next = 1'b0;
      if (is_comma && (comma_count != 4'(nmea_rmc_pkg::COMMA_MAX))) begin
        comma_count_next = comma_inc;
        if (comma_inc == 4'(nmea_rmc_pkg::FIELD_STATUS)) status_pending_next = 1'b1;
        if (comma_inc == 4'(nmea_rmc_pkg::FIELD_LAT)) begin
          rem_lat_next = 4'(nmea_rmc_pkg::LAT_LEN);
        end
        if (comma_inc == 4'(nmea_rmc_pkg::FIELD_LAT_HEMI)) rem_lath_next = 1'b1;
        if (comma_inc == 4'(nmea_rmc_pkg::FIELD_LON)) begin
          rem_lon_next = 4'(nmea_rmc_pkg::LON_LEN);
        end
        if (comma_inc == 4'(nmea_rmc_pkg::FIELD_LON_HEMI)) rem_lonh_next = 1'b1;
        if (comma_inc == 4'(nmea_rmc_pkg::FIELD_DATE)) begin
          rem_date_next = 3'(nmea_rmc_pkg::DATE_LEN);
        end
      end
      if (is_lf) begin
        in_sentence_next    = 1'b0;
        comma_count_next    = '0;
        status_pending_next = 1'b0;
        rem_time_next       = '0;
        rem_date_next       = '0;
        rem_lat_next        = '0;
        rem_lath_next       = 1'b0;
        rem_lon_next        = '0;
        rem_lonh_next       = 1'b0;
      end
    end
  end

  // Payload next state: clear at sentence start, keep captures otherwise
  always_comb begin
    if (hdr_done) begin
      status_char_next = '0;
      time_w_next      = '{default: '0};
      date_w_next      = '{default: '0};
      lat_w_next       = '{default: '0};
      lath_w_next      = '0;
      lon_deg_w_next   = '{default: '0};
      lon_min_w_next   = '{default: '0};
      lonh_w_next      = '0;
    end else begin
      status_char_next = status_cap;
      time_w_next      = time_cap;
      date_w_next      = date_cap;
      lat_w_next       = lat_cap;
      lath_w_next      = lath_cap;
      lon_deg_w_next   = lon_deg_cap;
      lon_min_w_next   = lon_min_cap;
      lonh_w_next      = lonh_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence    <= 1'b0;
      comma_count    <= '0;
      status_pending <= 1'b0;
      rem_time       <= '0;
      rem_date       <= '0;
      rem_lat        <= '0;
      rem_lath       <= 1'b0;
      rem_lon        <= '0;
      rem_lonh       <= 1'b0;
    end else begin
      in_sentence    <= in_sentence_next;
      comma_count    <= comma_count_next;
      status_pending <= status_pending_next;
      rem_time       <= rem_time_next;
      rem_date       <= rem_date_next;
      rem_lat        <= rem_lat_next;
      rem_lath       <= rem_lath_next;
      rem_lon        <= rem_lon_next;
      rem_lonh       <= rem_lonh_next;
    end
  end

  always_ff @(posedge clk) begin
    status_char <= status_char_next;
    time_w      <= time_w_next;
    date_w      <= date_w_next;
    lat_w       <= lat_w_next;
    lath_w      <= lath_w_next;
    lon_deg_w   <= lon_deg_w_next;
    lon_min_w   <= lon_min_w_next;
    lonh_w      <= lonh_w_next;
  end

  assign stat.in_sentence = in_sentence;
  assign stat.comma_count = comma_count;

endmodule

`default_nettype wire

FILE: rtl/nmea_rmc_outreg.sv
// Result register: holds one extracted fix until the sink takes it.
`default_nettype none

module nmea_rmc_outreg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire nmea_rmc_pkg::fix_t d,
  nmea_rmc_out_if.source          fix
);

  logic               valid;
  logic               valid_next;
  nmea_rmc_pkg::fix_t data;

  // Set on load, drop once the transaction completes
  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (fix.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= d;
    end
  end

  assign fix.valid            = valid;
  assign fix.fix_valid        = data.fix_valid;
  assign fix.utc_time_chars   = data.utc_time_chars;
  assign fix.date_chars       = data.date_chars;
  assign fix.latitude_chars   = data.latitude_chars;
  assign fix.lat_hemisphere   = data.lat_hemisphere;
  assign fix.lon_degree_chars = data.lon_degree_chars;
  assign fix.lon_minute_chars = data.lon_minute_chars;
  assign fix.lon_hemisphere   = data.lon_hemisphere;

endmodule

`default_nettype wire

FILE: rtl/nmea_rmc_field_extractor.sv
// Top level of the RMC sentence field extractor.
`default_nettype none
`include "nmea_rmc_field_extractor_assert.svh"

// Takes one received character per cycle on rx while rx.ready is high and emits
// one fix transaction on fix for every newline that closes a "$GPRMC," sentence,
// in the cycle after the newline is taken. Each byte is handled by the header
// matcher and the sentence tracker, whose result goes straight into the output
// register, so the sustained rate is one byte per clock unless stalled. rx.ready
// falls only while a finished fix sits in the output register and fix.ready is
// low; the register stage is the only buffering. Fields of a sentence whose
// status is not 'A' or that has fewer than nine commas come out as zero.

module nmea_rmc_field_extractor (
  input  wire logic      clk,
  input  wire logic      rst,
  nmea_rmc_in_if.sink    rx,
  nmea_rmc_out_if.source fix
);

  logic                     rx_take;
  nmea_rmc_pkg::hdr_stat_t  hdr_stat;
  nmea_rmc_pkg::sent_stat_t sent_stat;
  logic                     res_valid;
  nmea_rmc_pkg::fix_t       res;

  // Accept while the result register is free or draining
  assign rx.ready = !fix.valid || fix.ready;
  assign rx_take  = rx.valid && rx.ready;

  nmea_rmc_hdr u_hdr (
    .clk         (clk),
    .rst         (rst),
    .byte_take   (rx_take),
    .rx_byte     (rx.rx_byte),
    .in_sentence (sent_stat.in_sentence),
    .stat        (hdr_stat)
  );

  nmea_rmc_fields u_fields (
    .clk       (clk),
    .rst       (rst),
    .byte_take (rx_take),
    .rx_byte   (rx.rx_byte),
    .hdr_done  (hdr_stat.done),
    .res_valid (res_valid),
    .res       (res),
    .stat      (sent_stat)
  );

  nmea_rmc_outreg u_outreg (
    .clk  (clk),
    .rst  (rst),
    .load (res_valid),
    .d    (res),
    .fix  (fix)
  );

  `NMEA_RMC_ASSERT_IMP(a_hdr_idle_in_sentence, clk, rst, sent_stat.in_sentence, hdr_stat.pos == 3'd0, "header matcher active inside a sentence")
  `NMEA_RMC_ASSERT_IMP(a_comma_nonzero, clk, rst, sent_stat.in_sentence, sent_stat.comma_count != 4'd0, "comma count zero inside a sentence")
  `NMEA_RMC_ASSERT_NXT(a_hdr_opens, clk, rst, hdr_stat.done, sent_stat.in_sentence && (sent_stat.comma_count == 4'd1), "header did not open a sentence")
  `NMEA_RMC_ASSERT_NXT(a_lf_emits, clk, rst, rx_take && sent_stat.in_sentence && (rx.rx_byte == nmea_rmc_pkg::CHAR_LF), fix.valid && !sent_stat.in_sentence, "newline did not emit a fix")

endmodule

`default_nettype wire
